// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL, included by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

// ----- sv/dpc_pkg.sv -----
// Shared types and constants for the disparity to point cloud block.
package dpc_pkg;
    localparam int DIV_W = 48;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic mul;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;

    localparam logic [2:0] REG_W = 3'd0;
    localparam logic [2:0] REG_H = 3'd1;
    localparam logic [2:0] REG_OFS = 3'd2;
    localparam logic [2:0] REG_B = 3'd3;
    localparam logic [2:0] REG_F = 3'd4;
    localparam logic [2:0] REG_STEP = 3'd5;
endpackage

// ----- sv/dpc_ctrl.sv -----
// Controller sequencing multiply, divide and output for one item.
module dpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic              i_out_ready,
    input  dpc_pkg::t_status  i_status,
    output dpc_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_out_valid
);
    import dpc_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_go) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- sv/dpc_datapath.sv -----
// Datapath: numerators, three shared-clock restoring dividers, saturation.
module dpc_datapath #(
    parameter int FRAC_BITS = 4
) (
    input  logic              i_clk,
    input  dpc_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_disp,
    input  logic [9:0]        i_ofs,
    input  logic [11:0]       i_b,
    input  logic [13:0]       i_f,
    input  logic signed [15:0] i_u1,
    input  logic signed [15:0] i_v1,
    output dpc_pkg::t_status  o_status,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic [30:0]       o_z
);
    import dpc_pkg::*;
    localparam int CW = $clog2(DIV_W + 1);

    logic [10:0] r_d;
    logic signed [16:0] r_sum;
    logic signed [15:0] r_v1;
    logic [11:0] r_b;
    logic [13:0] r_f;
    logic [DIV_W-1:0] r_nz, r_nx, r_ny;
    logic r_sx, r_sy;
    logic [DIV_W-1:0] r_qz, r_qx, r_qy;
    logic [11:0] r_rz, r_rx, r_ry;
    logic [CW-1:0] r_cnt;

    logic [11:0] n_rz, n_rx, n_ry;
    logic [12:0] tz, tx, ty;
    logic [11:0] d2;
    logic signed [29:0] px;
    logic signed [27:0] py;

    assign d2 = {r_d, 1'b0};
    assign px = 30'(r_sum) * $signed({1'b0, r_b});
    assign py = 28'(r_v1) * $signed({1'b0, r_b});
    assign o_status.div_last = (r_cnt == CW'(1));

    always_comb begin
        tz = {r_rz, r_nz[DIV_W-1]};
        tx = {r_rx, r_nx[DIV_W-1]};
        ty = {r_ry, r_ny[DIV_W-1]};
        n_rz = (tz >= {2'b0, r_d}) ? 12'(tz - {2'b0, r_d}) : tz[11:0];
        n_rx = (tx >= {1'b0, d2}) ? 12'(tx - {1'b0, d2}) : tx[11:0];
        n_ry = (ty >= {2'b0, r_d}) ? 12'(ty - {2'b0, r_d}) : ty[11:0];
    end

    function automatic logic signed [31:0] sat(input logic neg, input logic [DIV_W-1:0] q);
        logic [DIV_W:0] v;
        v = {1'b0, q};
        if (!neg) return (v > (DIV_W+1)'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(q);
        if (v > (DIV_W+1)'(33'h80000000)) return 32'sh80000000;
        return -32'(q);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_d <= 11'(i_disp) + 11'(i_ofs);
            r_sum <= 17'(i_u1) + 17'(i_u1) + 17'(i_disp) + 17'(i_ofs);
            r_v1 <= i_v1;
            r_b <= i_b;
            r_f <= i_f;
        end
        if (i_cmd.mul) begin
            r_nz <= DIV_W'(26'(r_b) * 26'(r_f)) << FRAC_BITS;
            r_sx <= (px > 0);
            r_nx <= DIV_W'(px < 0 ? -px : px) << FRAC_BITS;
            r_sy <= (py < 0);
            r_ny <= DIV_W'(py < 0 ? -py : py) << FRAC_BITS;
            r_rz <= '0; r_rx <= '0; r_ry <= '0;
            r_cnt <= CW'(DIV_W);
        end else if (i_cmd.div_step) begin
            r_rz <= n_rz; r_rx <= n_rx; r_ry <= n_ry;
            r_nz <= r_nz << 1; r_nx <= r_nx << 1; r_ny <= r_ny << 1;
            r_qz <= {r_qz[DIV_W-2:0], tz >= {2'b0, r_d}};
            r_qx <= {r_qx[DIV_W-2:0], tx >= {1'b0, d2}};
            r_qy <= {r_qy[DIV_W-2:0], ty >= {2'b0, r_d}};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.finish) begin
            o_x <= sat(r_sx, {r_qx[DIV_W-2:0], tx >= {1'b0, d2}});
            o_y <= sat(r_sy, {r_qy[DIV_W-2:0], ty >= {2'b0, r_d}});
            o_z <= 31'(sat(1'b0, {r_qz[DIV_W-2:0], tz >= {2'b0, r_d}}));
        end
    end
endmodule

// ----- sv/disparity_to_point_cloud.sv -----
// Top level: config registers, raster counters, controller and datapath.
// Usage: pixels enter on i_disparity with i_valid/o_ready in raster order.
// Counters wrap at frame_width x frame_height. A pixel on the grid_step grid
// with nonzero disparity gives one point on o_point_* with o_valid/i_ready.
// Other pixels are taken and give nothing.
// A reprojected pixel passes a load step, a multiply step and the
// bit-per-cycle restoring dividers (X, Y, Z share one counter), then
// the result holds until taken. While a result waits the block takes no
// pixel; a stalled receiver stalls the input. Reset restores register
// defaults and zeroes the raster counters.
// Registers on APB at byte address 4*i; pready is always high.
// Results: 4 fractional bits, truncated toward zero and saturated.
module disparity_to_point_cloud #(
    parameter int MAX_DIM = 4096,
    parameter int FRAC_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_disparity,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic [30:0]       o_point_z,
    output logic [11:0]       o_src_row,
    output logic [11:0]       o_src_col,
    output logic              o_frame_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dpc_pkg::*;
    `include "assert_macros.svh"
    localparam int DW = $clog2(MAX_DIM + 1);

    logic [12:0] r_w, r_h;
    logic [9:0] r_ofs;
    logic [11:0] r_b;
    logic [13:0] r_f;
    logic [6:0] r_step;
    logic [DW-1:0] r_row, r_col;
    logic [5:0] r_rph, r_cph;
    logic [11:0] r_orow, r_ocol;
    logic r_odone;

    t_cmd cmd;
    t_status status;
    logic busy, go, acc;
    logic [DW-1:0] w_e, h_e;
    logic [6:0] step_e;
    logic col_wrap, row_wrap;
    logic signed [15:0] u1, v1;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    always_comb begin
        unique case (ridx)
            REG_W: prdata = 32'(r_w);
            REG_H: prdata = 32'(r_h);
            REG_OFS: prdata = 32'(r_ofs);
            REG_B: prdata = 32'(r_b);
            REG_F: prdata = 32'(r_f);
            REG_STEP: prdata = 32'(r_step);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 13'd640; r_h <= 13'd480; r_ofs <= 10'd200;
            r_b <= 12'd160; r_f <= 14'd3740; r_step <= 7'd10;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_W: r_w <= pwdata[12:0];
                REG_H: r_h <= pwdata[12:0];
                REG_OFS: r_ofs <= pwdata[9:0];
                REG_B: r_b <= pwdata[11:0];
                REG_F: r_f <= pwdata[13:0];
                REG_STEP: r_step <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // clamp sizes and step
    always_comb begin
        if (r_w == '0) w_e = DW'(1);
        else if (32'(r_w) > MAX_DIM) w_e = DW'(MAX_DIM);
        else w_e = DW'(r_w);
        if (r_h == '0) h_e = DW'(1);
        else if (32'(r_h) > MAX_DIM) h_e = DW'(MAX_DIM);
        else h_e = DW'(r_h);
        if (r_step == '0) step_e = 7'd1;
        else if (r_step > 7'd64) step_e = 7'd64;
        else step_e = r_step;
    end

    assign col_wrap = (32'(r_col) + 1 >= 32'(w_e));
    assign row_wrap = (32'(r_row) + 1 >= 32'(h_e));
    assign u1 = 16'(r_col) - 16'(w_e >> 1);
    assign v1 = 16'(r_row) - 16'(h_e >> 1);
    assign o_ready = !busy;
    assign acc = i_valid && o_ready;
    assign go = acc && i_disparity != 8'd0 && r_rph == '0 && r_cph == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0; r_rph <= '0; r_cph <= '0;
        end else if (acc) begin
            if (col_wrap) begin
                r_col <= '0; r_cph <= '0;
                if (row_wrap) begin
                    r_row <= '0; r_rph <= '0;
                end else begin
                    r_row <= r_row + DW'(1);
                    r_rph <= (7'(r_rph) + 7'd1 >= step_e) ? 6'd0 : r_rph + 6'd1;
                end
            end else begin
                r_col <= r_col + DW'(1);
                r_cph <= (7'(r_cph) + 7'd1 >= step_e) ? 6'd0 : r_cph + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_orow <= 12'(r_row); r_ocol <= 12'(r_col);
            r_odone <= col_wrap && row_wrap;
        end
    end
    assign o_src_row = r_orow;
    assign o_src_col = r_ocol;
    assign o_frame_done = r_odone;

    dpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_out_ready(i_ready),
        .i_status(status), .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_valid)
    );

    dpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_disp(i_disparity), .i_ofs(r_ofs),
        .i_b(r_b), .i_f(r_f), .i_u1(u1), .i_v1(v1), .o_status(status),
        .o_x(o_point_x), .o_y(o_point_y), .o_z(o_point_z)
    );

    `ASSERT_CLK(a_valid_busy, i_clk, i_rst_n, !o_valid || busy, "valid while idle")
    `ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, go, busy && !o_valid, "go not taken")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_point_x) && $stable(o_src_row), "item changed while waiting")
endmodule

// ----- test/tb_top.sv -----
// Testbench for disparity_to_point_cloud: directed and random pixel streams checked against a point predictor.
`timescale 1ns / 1ps

module tb_top;
    import dpc_pkg::*;

    // Result of one reprojected pixel, laid out as the output ports
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        z;
        logic [11:0]        row;
        logic [11:0]        col;
        logic               done;
    } t_point;

    localparam int  SETTLE_CYC = 60;        // longer than one reprojection
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  HOLD_CYC = 600;         // long receiver hold-off
    localparam int  HOLD_AT = 20;           // points seen before the hold-off
    localparam int  DIM_MAX = 4096;
    localparam int  STEP_MAX = 64;
    localparam longint SCALE = 16;          // 4 fractional bits

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_disparity = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic [30:0] o_point_z;
    logic [11:0] o_src_row;
    logic [11:0] o_src_col;
    logic        o_frame_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    disparity_to_point_cloud dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers (masked to register widths)
    logic [12:0] cfg_width = 13'd640;
    logic [12:0] cfg_height = 13'd480;
    logic [9:0]  cfg_offset = 10'd200;
    logic [11:0] cfg_base = 12'd160;
    logic [13:0] cfg_focal = 14'd3740;
    logic [6:0]  cfg_step = 7'd10;

    // Predictor raster position
    int unsigned pos_row = 0;
    int unsigned pos_col = 0;
    int unsigned phase_row = 0;
    int unsigned phase_col = 0;

    logic [7:0]  pixel_q[$];
    t_point      point_q[$];
    int          errors = 0;
    int          points_predicted = 0;
    int          points_seen = 0;
    int          cycles = 0;
    bit          calm = 1'b0;        // no idling on either side
    bit          held = 1'b0;
    int          hold_left = 0;

    function automatic void queue_pixel(logic [7:0] v);
        pixel_q = {pixel_q, v};
    endfunction

    function automatic longint dim_eff(logic [12:0] v);
        if (v == 0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the raster by one pixel; queue a point when the pixel reprojects
    function automatic void project_pixel(logic [7:0] disp);
        longint w, h, d, b, f, u1, u2, v1, r, c;
        int unsigned stp;
        bit col_wrap, row_wrap;
        t_point p;
        w = dim_eff(cfg_width);
        h = dim_eff(cfg_height);
        stp = (cfg_step == 0) ? 1 : (cfg_step > STEP_MAX) ? STEP_MAX : cfg_step;
        r = pos_row;
        c = pos_col;
        col_wrap = (c + 1 >= w);
        row_wrap = (r + 1 >= h);
        if (disp != 0 && phase_row == 0 && phase_col == 0) begin
            d = longint'(disp) + longint'(cfg_offset);
            b = cfg_base;
            f = cfg_focal;
            u1 = c - w / 2;
            u2 = u1 + d;
            v1 = r - h / 2;
            p.z = 31'(sat32((b * f * SCALE) / d));
            p.x = 32'(sat32((-(b * (u1 + u2)) * SCALE) / (2 * d)));
            p.y = 32'(sat32((b * v1 * SCALE) / d));
            p.row = pos_row[11:0];
            p.col = pos_col[11:0];
            p.done = col_wrap && row_wrap;
            point_q = {point_q, p};
            points_predicted++;
        end
        if (col_wrap) begin
            pos_col = 0;
            phase_col = 0;
            if (row_wrap) begin
                pos_row = 0;
                phase_row = 0;
            end else begin
                pos_row++;
                phase_row = (phase_row + 1 >= stp) ? 0 : phase_row + 1;
            end
        end else begin
            pos_col++;
            phase_col = (phase_col + 1 >= stp) ? 0 : phase_col + 1;
        end
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 38);
    endfunction

    // Driver: valid stays up with a steady payload until the item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                project_pixel(i_disparity);
            if (!i_valid || o_ready) begin
                if (pixel_q.size() != 0 && !idle_now()) begin
                    i_valid <= 1'b1;
                    i_disparity <= pixel_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!held && points_seen >= HOLD_AT) begin
            held <= 1'b1;
            hold_left <= HOLD_CYC;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: random backpressure, field checks
    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (point_q.size() == 0) begin
                    $error("point with nothing expected: row %0d col %0d",
                           o_src_row, o_src_col);
                    errors++;
                end else begin
                    e = point_q.pop_front();
                    if (o_point_x !== e.x) begin
                        $error("point_x expected %0d got %0d", e.x, o_point_x);
                        errors++;
                    end
                    if (o_point_y !== e.y) begin
                        $error("point_y expected %0d got %0d", e.y, o_point_y);
                        errors++;
                    end
                    if (o_point_z !== e.z) begin
                        $error("point_z expected %0d got %0d", e.z, o_point_z);
                        errors++;
                    end
                    if (o_src_row !== e.row) begin
                        $error("src_row expected %0d got %0d", e.row, o_src_row);
                        errors++;
                    end
                    if (o_src_col !== e.col) begin
                        $error("src_col expected %0d got %0d", e.col, o_src_col);
                        errors++;
                    end
                    if (o_frame_done !== e.done) begin
                        $error("frame_done expected %0d got %0d", e.done, o_frame_done);
                        errors++;
                    end
                end
                points_seen++;
            end
            if (hold_left > 0)
                i_ready <= 1'b0;
            else
                i_ready <= !idle_now();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Two-phase APB write; predictor copy follows at the write edge
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_W:    cfg_width = val[12:0];
            REG_H:    cfg_height = val[12:0];
            REG_OFS:  cfg_offset = val[9:0];
            REG_B:    cfg_base = val[11:0];
            REG_F:    cfg_focal = val[13:0];
            REG_STEP: cfg_step = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int w, int h, int ofs, int b, int f, int stp);
        reg_write(REG_W, w);
        reg_write(REG_H, h);
        reg_write(REG_OFS, ofs);
        reg_write(REG_B, b);
        reg_write(REG_F, f);
        reg_write(REG_STEP, stp);
    endtask

    // Drain all pixels and points, then let a last reprojection finish
    task automatic wait_quiet();
        while (pixel_q.size() != 0 || i_valid || point_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_pixel();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 12) return 8'd0;
        if (sel < 18) return 8'd255;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic int rand_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) return 0;
        if (sel < 6) return 8191;
        if (sel < 9) return $urandom_range(4090, 4096);
        return $urandom_range(1, 24);
    endfunction

    initial begin
        int phase_no;
        int items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: the origin reprojects, the next pixels are off grid
        queue_pixel(8'd255);
        queue_pixel(8'd1);
        queue_pixel(8'd0);
        wait_quiet();

        // One-pixel frame, every pixel on grid and last of frame
        set_all(1, 1, 0, 4095, 16383, 1);
        queue_pixel(8'd1);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd128);
        wait_quiet();

        // Zero sizes and step act as 1; offset at its top, baseline and focal length at one
        set_all(0, 0, 1023, 1, 1, 0);
        queue_pixel(8'd255);
        queue_pixel(8'd1);
        wait_quiet();

        // Oversized registers clamp to the maximum dimension and step
        set_all(8191, 8191, 0, 4095, 16383, 127);
        queue_pixel(8'd1);
        queue_pixel(8'd170);
        queue_pixel(8'd85);
        wait_quiet();

        // Shrink mid-frame: counters beyond the new limits wrap on advance
        set_all(3, 2, 5, 100, 500, 2);
        for (int i = 0; i < 8; i++)
            queue_pixel(8'(i + 1));
        wait_quiet();

        // Random phases, one of them with no idling at all
        items = 0;
        phase_no = 0;
        while (items < 600 || points_predicted < 40) begin
            calm = (phase_no == 3);
            set_all(rand_dim(), rand_dim(), $urandom_range(0, 1023),
                    ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 4095),
                    ($urandom_range(0, 9) == 0) ? 16383 : $urandom_range(1, 16383),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, 4));
            for (int i = 0; i < 60; i++)
                queue_pixel(rand_pixel());
            items += 60;
            phase_no++;
            wait_quiet();
        end
        calm = 1'b0;

        if (errors == 0 && point_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/dpc_pkg.sv
sv/dpc_ctrl.sv
sv/dpc_datapath.sv
sv/disparity_to_point_cloud.sv
test/tb_top.sv
